// ===== src/fegp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fegp_pkg: shared types and constants of the flit exit guard
// Field widths, stream packing, status and port codes, and the
// request/status structs between the top level and the pairing table.
// ----------------------------------------------------------------------------
package fegp_pkg;

	// field widths
	localparam int KIND_W    = 3;
	localparam int ID_W      = 32;
	localparam int GEN_W     = 16;
	localparam int COORD_W   = 8;
	localparam int TARGET_W  = 2 * COORD_W;
	localparam int PAYLOAD_W = 64;
	localparam int PORT_W    = 3;
	localparam int ERR_W     = 3;

	// default number of pairing table entries
	localparam int TABLE_DEPTH_DEF = 16;

	// stream packing
	localparam int TDATA_RAW_W = ID_W + GEN_W + 2 * COORD_W + 1 + PAYLOAD_W;
	localparam int TDATA_W     = ((TDATA_RAW_W + 7) / 8) * 8;
	localparam int S_TUSER_W   = KIND_W;
	localparam int M_TUSER_W   = PORT_W + 1 + ERR_W;

	// bit offsets inside tdata, lowest field first
	localparam int ID_LSB      = 0;
	localparam int GEN_LSB     = ID_LSB + ID_W;
	localparam int TX_LSB      = GEN_LSB + GEN_W;
	localparam int TY_LSB      = TX_LSB + COORD_W;
	localparam int CODED_LSB   = TY_LSB + COORD_W;
	localparam int PAYLOAD_LSB = CODED_LSB + 1;

	// processing status carried by an incoming flit
	typedef enum logic [KIND_W-1:0] {
		KIND_ENCRYPT = 3'd0,
		KIND_ENCODE  = 3'd1,
		KIND_AUTH    = 3'd2,
		KIND_DECRYPT = 3'd3,
		KIND_VERIFY  = 3'd4
	} kind_t;

	// destination of a result
	typedef enum logic [PORT_W-1:0] {
		PORT_ENC  = 3'd0,
		PORT_AUTH = 3'd1,
		PORT_NET  = 3'd2,
		PORT_APP  = 3'd3,
		PORT_NONE = 3'd4
	} port_t;

	// error codes
	typedef enum logic [ERR_W-1:0] {
		ERR_OK      = 3'd0,
		ERR_NOMATCH = 3'd1,
		ERR_FULL    = 3'd2,
		ERR_STATUS  = 3'd3,
		ERR_DUP     = 3'd4
	} err_t;

	// pairing key of a stored flit
	typedef struct packed {
		logic                coded;
		logic [ID_W-1:0]     id;
		logic [GEN_W-1:0]    gen;
		logic [TARGET_W-1:0] target;
	} tbl_key_t;

	// table request: store a new entry or remove the matching one
	typedef struct packed {
		logic ins;
		logic del;
	} tbl_cmd_t;

	// table lookup status
	typedef struct packed {
		logic hit;
		logic full;
	} tbl_stat_t;

endpackage

// ===== src/fegp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fegp_ram: generic single-write, single-read RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fegp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/fegp_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fegp_table: pairing table of stored data flits
// Keys sit in flops and are matched in parallel; generation and payload of
// each entry also sit in a RAM that is read when a matching entry is removed.
// ----------------------------------------------------------------------------
module fegp_table
	import fegp_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tbl_key_t             key,
	input  logic [PAYLOAD_W-1:0] payload,
	input  tbl_cmd_t             cmd,
	output tbl_stat_t            stat,
	output logic [GEN_W-1:0]     rd_gen,
	output logic [PAYLOAD_W-1:0] rd_payload
);

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int RAM_W = GEN_W + PAYLOAD_W;

	logic [TABLE_DEPTH-1:0] valid_q;
	tbl_key_t               key_q [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] match;
	logic [IDX_W-1:0]       hit_idx;
	logic [IDX_W-1:0]       free_idx;
	logic [RAM_W-1:0]       rdata;

	// parallel key compare, generation only counts for coded flits
	always_comb begin
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			match[i] = valid_q[i] && (key_q[i].coded == key.coded)
				&& (key_q[i].id == key.id) && (key_q[i].target == key.target)
				&& (!key.coded || (key_q[i].gen == key.gen));
		end
	end

	// index of the matching entry, at most one can match
	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			if (match[i]) begin
				hit_idx = hit_idx | IDX_W'(i);
			end
		end
	end

	// lowest free entry
	always_comb begin
		free_idx = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_idx = IDX_W'(i);
			end
		end
	end

	assign stat.hit  = |match;
	assign stat.full = &valid_q;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.ins) begin
			valid_q[free_idx] <= 1'b1;
		end else if (cmd.del) begin
			valid_q[hit_idx] <= 1'b0;
		end
	end

	// key store
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			key_q[free_idx] <= key;
		end
	end

	// generation and payload store
	fegp_ram #(
		.WIDTH(RAM_W),
		.DEPTH(TABLE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.ins),
		.waddr(free_idx),
		.wdata({key.gen, payload}),
		.re   (cmd.del),
		.raddr(hit_idx),
		.rdata(rdata)
	);

	assign rd_gen     = rdata[RAM_W-1 -: GEN_W];
	assign rd_payload = rdata[PAYLOAD_W-1:0];

`ifndef NO_ASSERTIONS
	// duplicate keys are never stored, so at most one entry matches
	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match))
		else $error("more than one table entry matches the key");

	// a store only goes to a free entry and never duplicates a key
	a_ins_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins |-> (!stat.full && !stat.hit && !cmd.del))
		else $error("store into a full table or with a duplicate key");

	// a removal only touches a matching entry, which is gone afterwards
	a_del_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.del |-> (stat.hit ##1 !valid_q[$past(hit_idx)]))
		else $error("removal without a matching entry");
`endif

endmodule

// ===== src/flit_exit_guard_pairing.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flit_exit_guard_pairing: exit guard that routes and pairs tagged flits
// Routes flits by status and pairs stored data flits with their MAC flits.
// ----------------------------------------------------------------------------
// A flit is taken into an input register, decided in one pass against the
// pairing table, and its result is held in an output register. A flit with
// one result frees the output register as soon as m_tready takes it, so
// flits can stream in every cycle while m_tready stays high and no pair is
// being sent. A MAC flit that finds its data flit gives two results (stored
// data flit first, then the MAC flit), which the output register presents
// one after the other. The stored generation and payload are read from the
// table as the MAC flit enters the output register. Table keys are
// matched in parallel. The table is usable right after reset, with no
// clearing time. The user must write encode_enable through cfg_we/cfg_wdata
// only while no flit is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module flit_exit_guard_pairing
	import fegp_pkg::*;
#(
	parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration: encode_enable
	input  logic                 cfg_we,
	input  logic                 cfg_wdata,
	// incoming flits
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// tdata: flit_id, generation, target_x, target_y, coded, payload, zero fill
	input  logic [TDATA_W-1:0]   s_tdata,
	// tuser: kind
	input  logic [S_TUSER_W-1:0] s_tuser,
	// results
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// tdata: id_out, generation_out, target_x_out, target_y_out, coded_out,
	//        payload_out, zero fill
	output logic [TDATA_W-1:0]   m_tdata,
	// tuser: dest_port, status_out, error_code
	output logic [M_TUSER_W-1:0] m_tuser,
	output logic                 m_tlast
);

	// configuration
	logic encode_enable_q;

	// input stage
	logic                 valid_s1;
	kind_t                kind_s1;
	logic [ID_W-1:0]      id_s1;
	logic [GEN_W-1:0]     gen_s1;
	logic [COORD_W-1:0]   tx_s1;
	logic [COORD_W-1:0]   ty_s1;
	logic                 coded_s1;
	logic [PAYLOAD_W-1:0] payload_s1;

	// output stage
	logic                 valid_s2;
	logic                 pair_s2;
	port_t                port_s2;
	logic                 status_s2;
	logic [ID_W-1:0]      id_s2;
	logic [GEN_W-1:0]     gen_s2;
	logic [COORD_W-1:0]   tx_s2;
	logic [COORD_W-1:0]   ty_s2;
	logic                 coded_s2;
	logic [PAYLOAD_W-1:0] payload_s2;
	err_t                 err_s2;

	// decision
	tbl_key_t             key;
	tbl_cmd_t             cmd;
	tbl_stat_t            stat;
	logic [GEN_W-1:0]     rd_gen;
	logic [PAYLOAD_W-1:0] rd_payload;
	port_t                port_d;
	logic                 status_d;
	logic                 coded_d;
	logic                 pair_d;
	logic                 ins_d;
	logic                 del_d;
	err_t                 err_d;
	logic                 out_done;
	logic                 s2_free;
	logic                 advance;

	// handshake
	assign out_done = valid_s2 && m_tready && !pair_s2;
	assign s2_free  = !valid_s2 || out_done;
	assign advance  = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s2_free;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			encode_enable_q <= 1'b0;
		end else if (cfg_we) begin
			encode_enable_q <= cfg_wdata;
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// input stage data
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1    <= kind_t'(s_tuser);
			id_s1      <= s_tdata[ID_LSB +: ID_W];
			gen_s1     <= s_tdata[GEN_LSB +: GEN_W];
			tx_s1      <= s_tdata[TX_LSB +: COORD_W];
			ty_s1      <= s_tdata[TY_LSB +: COORD_W];
			coded_s1   <= s_tdata[CODED_LSB];
			payload_s1 <= s_tdata[PAYLOAD_LSB +: PAYLOAD_W];
		end
	end

	// lookup key: stores use the class of their status, MAC flits their own flag
	always_comb begin
		key.coded  = (kind_s1 == KIND_ENCODE) ? 1'b1 :
			(kind_s1 == KIND_ENCRYPT) ? 1'b0 : coded_s1;
		key.id     = id_s1;
		key.gen    = gen_s1;
		key.target = {tx_s1, ty_s1};
	end

	// routing decision
	always_comb begin
		port_d   = PORT_APP;
		status_d = 1'b0;
		coded_d  = coded_s1;
		pair_d   = 1'b0;
		ins_d    = 1'b0;
		del_d    = 1'b0;
		err_d    = ERR_OK;
		case (kind_s1)
			KIND_ENCRYPT, KIND_ENCODE: begin
				if (kind_s1 == KIND_ENCRYPT && encode_enable_q) begin
					port_d   = PORT_ENC;
					status_d = 1'b1;
				end else if (stat.hit) begin
					err_d = ERR_DUP;
				end else if (stat.full) begin
					err_d = ERR_FULL;
				end else begin
					port_d  = PORT_AUTH;
					coded_d = key.coded;
					ins_d   = 1'b1;
				end
			end
			KIND_AUTH: begin
				if (stat.hit) begin
					port_d = PORT_NET;
					pair_d = 1'b1;
					del_d  = 1'b1;
				end else begin
					err_d = ERR_NOMATCH;
				end
			end
			KIND_DECRYPT, KIND_VERIFY: begin
				port_d = PORT_APP;
			end
			default: begin
				err_d = ERR_STATUS;
			end
		endcase
		if (err_d != ERR_OK) begin
			port_d = PORT_NONE;
		end
	end

	assign cmd.ins = advance && ins_d;
	assign cmd.del = advance && del_d;

	// pairing table
	fegp_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.key       (key),
		.payload   (payload_s1),
		.cmd       (cmd),
		.stat      (stat),
		.rd_gen    (rd_gen),
		.rd_payload(rd_payload)
	);

	// output stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			pair_s2  <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
			pair_s2  <= pair_d;
		end else if (valid_s2 && m_tready) begin
			if (pair_s2) begin
				pair_s2 <= 1'b0;
			end else begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// output stage data, error results carry an all-zero flit
	always_ff @(posedge clk) begin
		if (advance) begin
			port_s2 <= port_d;
			err_s2  <= err_d;
			if (err_d != ERR_OK) begin
				status_s2  <= 1'b0;
				id_s2      <= '0;
				gen_s2     <= '0;
				tx_s2      <= '0;
				ty_s2      <= '0;
				coded_s2   <= 1'b0;
				payload_s2 <= '0;
			end else begin
				status_s2  <= status_d;
				id_s2      <= id_s1;
				gen_s2     <= gen_s1;
				tx_s2      <= tx_s1;
				ty_s2      <= ty_s1;
				coded_s2   <= coded_d;
				payload_s2 <= payload_s1;
			end
		end
	end

	// result ports, the stored flit of a pair takes generation and payload
	// from the table
	assign m_tvalid = valid_s2;
	assign m_tlast  = !pair_s2;
	assign m_tuser  = {err_s2, status_s2, port_s2};
	assign m_tdata  = {
		{(TDATA_W - TDATA_RAW_W){1'b0}},
		pair_s2 ? rd_payload : payload_s2,
		coded_s2,
		ty_s2,
		tx_s2,
		pair_s2 ? rd_gen : gen_s2,
		id_s2
	};

`ifndef NO_ASSERTIONS
	// the first result of a pair is always followed by the second
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tlast) |=> (m_tvalid && m_tlast))
		else $error("second result of a pair missing");

	// an error result goes nowhere and ends its request
	a_err_none: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && err_s2 != ERR_OK) |-> (port_s2 == PORT_NONE && m_tlast))
		else $error("error result with a destination");

	// a pair is always sent to the network
	a_pair_net: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && pair_s2) |-> (port_s2 == PORT_NET && err_s2 == ERR_OK))
		else $error("paired result not routed to the network");
`endif

endmodule
